@@ sv/qte_pkg.sv @@
// Shared constants, types and helper functions for the quaternion to Euler
// angle converter. No dependencies; qte_cordic and the top level import this package.
`default_nettype none
package qte_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int CIN_W = 18;
  localparam int XW = 36;
  localparam int ZW = 36;
  localparam int MAG_W = 17;
  localparam int THR_W = 15;
  localparam int ANG_W = 16;
  localparam int TERM_W = 16;

  localparam logic signed [ZW-1:0] PI_Q30 = 36'sd3373259426;
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  localparam logic signed [34:0] ONE_Q28 = 35'sd268435456;
  localparam logic signed [ANG_W-1:0] ANGLE_MAX = 16'sd25736;

  localparam logic signed [ZW-1:0] ATAN_TAB [24] = '{
    36'sd843314856, 36'sd497837829, 36'sd263043836, 36'sd133525158,
    36'sd67021686, 36'sd33543515, 36'sd16775850, 36'sd8388437,
    36'sd4194282, 36'sd2097149, 36'sd1048575, 36'sd524287,
    36'sd262143, 36'sd131071, 36'sd65535, 36'sd32767,
    36'sd16383, 36'sd8191, 36'sd4095, 36'sd2047,
    36'sd1023, 36'sd511, 36'sd255, 36'sd127
  };

  // Data that rides alongside a CORDIC pipeline.
  typedef struct packed {
    logic                     lock;
    logic signed [ANG_W-1:0]  yaw;
    logic signed [TERM_W-1:0] m32;
    logic signed [TERM_W-1:0] m12;
    logic signed [TERM_W-1:0] m22;
    logic signed [TERM_W-1:0] m11;
    logic signed [TERM_W-1:0] m21;
  } qte_side_t;

  // Round a Q28 matrix term to Q14 and saturate to 16 bits.
  function automatic logic signed [TERM_W-1:0] to_q14(input logic signed [34:0] v);
    logic signed [34:0] r;
    r = (v + 35'sd8192) >>> 14;
    if (r > 35'sd32767) r = 35'sd32767;
    if (r < -35'sd32768) r = -35'sd32768;
    return r[TERM_W-1:0];
  endfunction

  // Q30 angle to saturated Q2.13.
  function automatic logic signed [ANG_W-1:0] angle_out(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] r;
    r = (z + ZW'(65536)) >>> 17;
    if (r > ZW'(ANGLE_MAX)) r = ZW'(ANGLE_MAX);
    if (r < -ZW'(ANGLE_MAX)) r = -ZW'(ANGLE_MAX);
    return r[ANG_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ sv/qte_ifs.sv @@
// Valid/ready channel interfaces for the quaternion requests and the
// Euler angle results. Depends on nothing.
`default_nettype none
interface qte_quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface qte_euler_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  logic signed [15:0] roll_angle;
  logic               gimbal_lock;
  modport source (output valid, pitch_angle, yaw_angle, roll_angle, gimbal_lock,
                  input ready);
  modport sink (input valid, pitch_angle, yaw_angle, roll_angle, gimbal_lock,
                output ready);
endinterface
`default_nettype wire

@@ sv/qte_cordic.sv @@
// Pipelined CORDIC vectoring unit: angle and gain-corrected magnitude.
// Depends on qte_pkg.
`default_nettype none
module qte_cordic import qte_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire qte_side_t               in_side,
  input  wire logic signed [CIN_W-1:0] x_in,
  input  wire logic signed [CIN_W-1:0] y_in,
  output logic                         out_valid,
  output qte_side_t                    out_side,
  output logic signed [ZW-1:0]         ang_o,
  output logic [MAG_W-1:0]             mag_o
);

  localparam int N = CORDIC_STAGES;

  logic                 v_r    [0:N+1];
  qte_side_t            side_r [0:N+1];
  logic signed [XW-1:0] x_r    [0:N];
  logic signed [XW-1:0] y_r    [0:N];
  logic signed [ZW-1:0] z_r    [0:N];
  logic                 zero_r [0:N];
  logic [61:0]          prod_r;
  logic signed [ZW-1:0] ang_r;
  logic                 zf_r;

  logic signed [XW-1:0] xs, ys, x0, y0;
  logic signed [ZW-1:0] z0;
  logic                 zero0;
  logic [32:0]          mag_sum;

  // Bring the vector into the right half plane first.
  always_comb begin
    xs = XW'(x_in) <<< 14;
    ys = XW'(y_in) <<< 14;
    zero0 = (x_in == '0) && (y_in == '0);
    if (xs < 0) begin
      z0 = (ys >= 0) ? PI_Q30 : -PI_Q30;
      x0 = -xs;
      y0 = -ys;
    end else begin
      z0 = '0;
      x0 = xs;
      y0 = ys;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
    if (en) begin
      side_r[0] <= in_side;
      x_r[0]    <= x0;
      y_r[0]    <= y0;
      z_r[0]    <= z0;
      zero_r[0] <= zero0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [XW-1:0] dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
      if (en) begin
        side_r[i+1] <= side_r[i];
        zero_r[i+1] <= zero_r[i];
        if (!y_r[i][XW-1]) begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + ATAN_TAB[i];
        end else begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - ATAN_TAB[i];
        end
      end
    end
  end

  // Gain correction; x is non-negative after vectoring.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[N+1] <= 1'b0;
    end else if (en) begin
      v_r[N+1] <= v_r[N];
    end
    if (en) begin
      side_r[N+1] <= side_r[N];
      prod_r      <= 62'(x_r[N][31:0]) * 62'(INV_GAIN_Q30);
      ang_r       <= zero_r[N] ? '0 : z_r[N];
      zf_r        <= zero_r[N];
    end
  end

  assign mag_sum   = {1'b0, prod_r[61:30]} + 33'd8192;
  assign out_valid = v_r[N+1];
  assign out_side  = side_r[N+1];
  assign ang_o     = ang_r;
  assign mag_o     = zf_r ? '0 : mag_sum[MAG_W+13:14];

endmodule
`default_nettype wire

@@ sv/quaternion_to_euler_angles.sv @@
// Top level of the quaternion to Euler angle (YXZ) converter.
// Depends on qte_pkg, qte_ifs and qte_cordic.
`default_nettype none
// The block takes one Q1.14 quaternion request per clock while not stalled
// and returns pitch, yaw and roll in Q2.13 radians plus a gimbal-lock flag,
// in request order. The pipeline stages are the product register, the
// matrix term register, the yaw CORDIC with its gain multiply, the branch
// decision register, the parallel pitch and roll CORDICs, and the output
// register. The whole pipeline advances together; it holds only while a
// result waits at the output and the consumer is not ready, so with the
// consumer ready it accepts one request per cycle. The threshold register
// should be written only while no request is in flight.
module quaternion_to_euler_angles import qte_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  qte_quat_if.sink              in_ch,
  qte_euler_if.source           out_ch,
  input  wire logic             cfg_we,
  input  wire logic [THR_W-1:0] cfg_wdata
);

  logic en;
  logic [THR_W-1:0] thr_r;

  // Product stage.
  logic p_v_r;
  logic signed [31:0] xx_r, yy_r, zz_r, xz_r, yw_r, yz_r, xw_r, xy_r, zw_r;
  // Matrix term stage.
  logic m_v_r;
  logic signed [TERM_W-1:0] m31_r, m32_r, m33_r, m12_r, m22_r, m11_r, m21_r;
  // Yaw CORDIC.
  logic c1_v;
  qte_side_t c1_side, m_side;
  logic signed [ZW-1:0] c1_ang;
  logic [MAG_W-1:0] c1_mag;
  // Branch stage.
  logic s3_v_r;
  qte_side_t s3_side_r, s3_side_nxt;
  logic signed [CIN_W-1:0] px_r, py_r, rx_r, ry_r;
  logic lock_nxt;
  // Pitch and roll CORDICs.
  logic c2_v, c3_v;
  qte_side_t c2_side, c3_side;
  logic signed [ZW-1:0] c2_ang, c3_ang;
  // Output register.
  logic out_v_r, out_lock_r;
  logic signed [ANG_W-1:0] out_pitch_r, out_yaw_r, out_roll_r;

  assign en = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_W'(1);
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      m_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= in_ch.valid;
      m_v_r <= p_v_r;
    end
    if (en) begin
      xx_r <= 32'(in_ch.quat_x) * 32'(in_ch.quat_x);
      yy_r <= 32'(in_ch.quat_y) * 32'(in_ch.quat_y);
      zz_r <= 32'(in_ch.quat_z) * 32'(in_ch.quat_z);
      xz_r <= 32'(in_ch.quat_x) * 32'(in_ch.quat_z);
      yw_r <= 32'(in_ch.quat_y) * 32'(in_ch.quat_w);
      yz_r <= 32'(in_ch.quat_y) * 32'(in_ch.quat_z);
      xw_r <= 32'(in_ch.quat_x) * 32'(in_ch.quat_w);
      xy_r <= 32'(in_ch.quat_x) * 32'(in_ch.quat_y);
      zw_r <= 32'(in_ch.quat_z) * 32'(in_ch.quat_w);
      // Terms are exact in Q28 before rounding to Q14.
      m31_r <= to_q14((35'(xz_r) + 35'(yw_r)) <<< 1);
      m32_r <= to_q14((35'(yz_r) - 35'(xw_r)) <<< 1);
      m33_r <= to_q14(ONE_Q28 - (35'(xx_r) <<< 1) - (35'(yy_r) <<< 1));
      m12_r <= to_q14((35'(xy_r) + 35'(zw_r)) <<< 1);
      m22_r <= to_q14(ONE_Q28 - (35'(xx_r) <<< 1) - (35'(zz_r) <<< 1));
      m11_r <= to_q14(ONE_Q28 - (35'(yy_r) <<< 1) - (35'(zz_r) <<< 1));
      m21_r <= to_q14((35'(xy_r) - 35'(zw_r)) <<< 1);
    end
  end

  always_comb begin
    m_side      = '0;
    m_side.m32  = m32_r;
    m_side.m12  = m12_r;
    m_side.m22  = m22_r;
    m_side.m11  = m11_r;
    m_side.m21  = m21_r;
  end

  // Yaw angle and cy come from the vector (m33, m31).
  qte_cordic u_yaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (m_v_r),
    .in_side   (m_side),
    .x_in      (CIN_W'(m33_r)),
    .y_in      (CIN_W'(m31_r)),
    .out_valid (c1_v),
    .out_side  (c1_side),
    .ang_o     (c1_ang),
    .mag_o     (c1_mag)
  );

  // A small cy means the yaw axis is aligned with roll: gimbal lock.
  assign lock_nxt = !(c1_mag > MAG_W'(thr_r));

  // The side data picks up the branch decision and the finished yaw angle.
  always_comb begin
    s3_side_nxt      = c1_side;
    s3_side_nxt.lock = lock_nxt;
    s3_side_nxt.yaw  = angle_out(c1_ang);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= c1_v;
    end
    if (en) begin
      s3_side_r      <= s3_side_nxt;
      px_r           <= CIN_W'({1'b0, c1_mag});
      py_r           <= -CIN_W'(c1_side.m32);
      rx_r           <= lock_nxt ? CIN_W'(c1_side.m11) : CIN_W'(c1_side.m22);
      ry_r           <= lock_nxt ? -CIN_W'(c1_side.m21) : CIN_W'(c1_side.m12);
    end
  end

  qte_cordic u_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_v_r),
    .in_side   (s3_side_r),
    .x_in      (px_r),
    .y_in      (py_r),
    .out_valid (c2_v),
    .out_side  (c2_side),
    .ang_o     (c2_ang),
    .mag_o     ()
  );

  qte_cordic u_roll (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_v_r),
    .in_side   (s3_side_r),
    .x_in      (rx_r),
    .y_in      (ry_r),
    .out_valid (c3_v),
    .out_side  (c3_side),
    .ang_o     (c3_ang),
    .mag_o     ()
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= c2_v && c3_v;
    end
    if (en) begin
      out_pitch_r <= angle_out(c2_ang);
      out_roll_r  <= angle_out(c3_ang);
      out_yaw_r   <= c2_side.lock ? '0 : c2_side.yaw;
      out_lock_r  <= c3_side.lock;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.pitch_angle = out_pitch_r;
  assign out_ch.yaw_angle   = out_yaw_r;
  assign out_ch.roll_angle  = out_roll_r;
  assign out_ch.gimbal_lock = out_lock_r;

  // In gimbal lock the yaw field must read zero.
  a_lock_yaw: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_lock_r) |-> (out_yaw_r == '0))
    else $error("yaw not zero in gimbal lock");

  // Every delivered angle lies within the saturation bounds.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_pitch_r <= ANGLE_MAX && out_pitch_r >= -ANGLE_MAX &&
                 out_roll_r <= ANGLE_MAX && out_roll_r >= -ANGLE_MAX &&
                 out_yaw_r <= ANGLE_MAX && out_yaw_r >= -ANGLE_MAX))
    else $error("angle out of range");

  // A stall must not drop a request sitting in the pipeline.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && s3_v_r) |=> s3_v_r)
    else $error("request lost during stall");

endmodule
`default_nettype wire
